// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountOutW    = 5;

  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  localparam logic [StatusW-1:0] StatusDone      = 2'd0;
  localparam logic [StatusW-1:0] StatusFull      = 2'd1;
  localparam logic [StatusW-1:0] StatusEmptyRead = 2'd2;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain. On insert it keeps its entry, takes the new
// entry or takes its upper neighbour's entry; on remove it takes the entry
// of its lower neighbour.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_entry_i,
  input  logic               occupied_i,
  input  logic               take_prev_i,
  input  spq_pkg::entry_t    prev_entry_i,
  input  spq_pkg::entry_t    next_entry_i,
  output logic               take_o,
  output spq_pkg::entry_t    entry_o,
  output spq_pkg::entry_t    entry_d_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  assign take_o = !occupied_i || (entry_q.prio <= new_entry_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (take_prev_i) begin
        entry_d = prev_entry_i;
      end else if (take_o) begin
        entry_d = new_entry_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

// ===== src/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Holds up to Depth entries in descending priority order in a chain of cells.
// ----------------------------------------------------------------------------
// Each transaction is either an insert or a remove of the front entry and
// yields one result transaction. The block takes one transaction per cycle:
// every cell compares its priority with the new one in parallel and the whole
// chain shifts together, and the result is held in an output register
// so a new transaction is taken whenever that register is empty or is being
// read in the same cycle. A new entry goes ahead of the first entry whose
// priority is less than or equal to its own. Inserts into a full queue are
// rejected with status full and removes from an empty queue report status
// empty with zero removed fields. No clearing pass is needed after reset.
module sorted_priority_queue #(
  parameter int unsigned Depth = spq_pkg::DefaultDepth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic                                  kind_i,
  input  logic signed [spq_pkg::DataW-1:0]      item_value_i,
  input  logic signed [spq_pkg::DataW-1:0]      item_priority_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [spq_pkg::StatusW-1:0]           status_o,
  output logic signed [spq_pkg::DataW-1:0]      removed_value_o,
  output logic signed [spq_pkg::DataW-1:0]      removed_priority_o,
  output logic                                  front_valid_o,
  output logic signed [spq_pkg::DataW-1:0]      front_value_o,
  output logic signed [spq_pkg::DataW-1:0]      front_priority_o,
  output logic [spq_pkg::CountOutW-1:0]         entry_count_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            accept, full, empty;
  cell_ctrl_t      ctrl;
  entry_t          new_entry;
  entry_t          zero_entry;

  logic   [Depth:0]   take;
  entry_t [Depth-1:0] cell_q;
  entry_t [Depth-1:0] cell_d;

  logic                   out_valid_q;
  logic [StatusW-1:0]     status_q, status_d;
  entry_t                 removed_q, removed_d;
  entry_t                 front_q, front_d;
  logic                   front_valid_q;
  logic [CntW-1:0]        count_out_q;
  logic [CntW+CountOutW-1:0] count_ext;

  assign ready_o   = !out_valid_q || ready_i;
  assign accept    = valid_i && ready_o;
  assign full      = (count_q == CntW'(Depth));
  assign empty     = (count_q == '0);
  assign ctrl.ins  = accept && (kind_i == KindInsert) && !full;
  assign ctrl.rem  = accept && (kind_i == KindRemove) && !empty;
  assign new_entry = '{value: item_value_i, prio: item_priority_i};
  assign zero_entry = '0;

  assign take[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    entry_t prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = zero_entry;
    end else begin : g_mid
      assign prev_e = cell_q[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next_e = zero_entry;
    end else begin : g_inner
      assign next_e = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_entry_i  (new_entry),
      .occupied_i   (CntW'(i) < count_q),
      .take_prev_i  (take[i]),
      .prev_entry_i (prev_e),
      .next_entry_i (next_e),
      .take_o       (take[i+1]),
      .entry_o      (cell_q[i]),
      .entry_d_o    (cell_d[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    status_d  = StatusDone;
    removed_d = zero_entry;
    if (kind_i == KindInsert) begin
      if (full) begin
        status_d = StatusFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = StatusEmptyRead;
      end else begin
        count_d   = count_q - CntW'(1);
        removed_d = cell_q[0];
      end
    end
    front_d = (count_d != '0) ? cell_d[0] : zero_entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      removed_q     <= removed_d;
      front_q       <= front_d;
      front_valid_q <= (count_d != '0);
      count_out_q   <= count_d;
    end
  end

  assign count_ext = {{CountOutW{1'b0}}, count_out_q};

  assign valid_o            = out_valid_q;
  assign status_o           = status_q;
  assign removed_value_o    = removed_q.value;
  assign removed_priority_o = removed_q.prio;
  assign front_valid_o      = front_valid_q;
  assign front_value_o      = front_q.value;
  assign front_priority_o   = front_q.prio;
  assign entry_count_o      = count_ext[CountOutW-1:0];

endmodule
